/* rtl/core/hpgl_pen_command_parser_unit_defines.svh */
// assertion macros for the hpgl pen command parser
// expects clk and arst_n in the scope of use
`ifndef HPGL_PEN_COMMAND_PARSER_UNIT_DEFINES_SVH
`define HPGL_PEN_COMMAND_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define HPCP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HPCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/hpcp_pkg.sv */
// package for the hpgl pen command parser
// parse phases, command letter codes and character constants; no dependencies
package hpcp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LETTER,
		PH_AFTER_IN,
		PH_COORDS,
		PH_SIGN,
		PH_DIGITS,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		LET_NONE,
		LET_I,
		LET_P
	} letter_t;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_SEMI  = 8'd59;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_A     = 8'd65;
	localparam logic [7:0] CH_D     = 8'd68;
	localparam logic [7:0] CH_I     = 8'd73;
	localparam logic [7:0] CH_N     = 8'd78;
	localparam logic [7:0] CH_P     = 8'd80;
	localparam logic [7:0] CH_R     = 8'd82;
	localparam logic [7:0] CH_U     = 8'd85;

endpackage

/* rtl/core/hpgl_pen_command_parser_unit.sv */
// HPGL pen command parser: takes one character per cycle and emits one line segment
// per pen-down move, both ends scaled by SCALE. A character is taken in every cycle
// while the output side flows; the parse state updates in the cycle of the transfer,
// the segment endpoints are registered, then scaled by a constant multiplier into the
// result register. Relative moves saturate to the signed COORD_BITS range. Depends on
// hpcp_pkg and on hpgl_pen_command_parser_unit_defines.svh.
`include "hpgl_pen_command_parser_unit_defines.svh"

module hpgl_pen_command_parser_unit
	import hpcp_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int SCALE      = 100,
	localparam int OUT_BITS  = COORD_BITS + $clog2(SCALE)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 ch,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OUT_BITS-1:0] start_x,
	output logic signed [OUT_BITS-1:0] start_y,
	output logic signed [OUT_BITS-1:0] end_x,
	output logic signed [OUT_BITS-1:0] end_y
);

	localparam int TW = COORD_BITS + 4;
	localparam logic [TW-1:0] MAG_LIMIT = TW'(1) << (COORD_BITS - 1);
	localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [OUT_BITS-1:0] SCALE_W = OUT_BITS'(SCALE);

	function automatic logic signed [COORD_BITS-1:0] sat_add(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] s;
		s = (COORD_BITS+1)'(a) + (COORD_BITS+1)'(b);
		if (s[COORD_BITS] != s[COORD_BITS-1]) begin
			return s[COORD_BITS] ? C_MIN : C_MAX;
		end
		return s[COORD_BITS-1:0];
	endfunction

	// parse state
	phase_t                        phase_q, phase_d;
	letter_t                       letter_q, letter_d;
	logic                          drawing_q, drawing_d;
	logic                          rel_q, rel_d;
	logic signed [COORD_BITS-1:0]  pen_x_q, pen_x_d;
	logic signed [COORD_BITS-1:0]  pen_y_q, pen_y_d;
	logic signed [COORD_BITS-1:0]  held_x_q, held_x_d;
	logic [COORD_BITS-1:0]         accum_q, accum_d;
	logic                          neg_q, neg_d;
	logic                          wait_y_q, wait_y_d;

	// segment stage and result register
	logic                          seg_valid_s1;
	logic signed [COORD_BITS-1:0]  sx_s1, sy_s1, ex_s1, ey_s1;
	logic                          out_valid_q;
	logic signed [OUT_BITS-1:0]    start_x_q, start_y_q, end_x_q, end_y_q;

	logic                          accept, s2_ready, s1_ready;
	logic                          is_eol, is_sep, is_semi, is_digit, is_sign;
	logic [3:0]                    digit;
	logic [TW-1:0]                 next_accum;
	logic                          fin_bad, fin_seg, seg_v;
	logic signed [COORD_BITS-1:0]  fin_val, fin_x, fin_y;
	phase_t                        cc_phase;
	logic                          cc_num;
	logic [COORD_BITS-1:0]         cc_accum;
	logic                          cc_neg;

	assign s2_ready = !out_valid_q || !out_stall;
	assign s1_ready = !seg_valid_s1 || s2_ready;
	assign in_stall = !s1_ready;
	assign accept   = in_valid && !in_stall;

	assign is_eol   = (ch == CH_LF);
	assign is_semi  = (ch == CH_SEMI);
	assign is_sep   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_VT)
		|| (ch == CH_FF) || (ch == CH_COMMA);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
	assign digit    = 4'(ch - CH_ZERO);

	assign next_accum = (TW'(accum_q) << 3) + (TW'(accum_q) << 1) + TW'(digit);

	// completion of the pending number
	assign fin_bad = !neg_q && accum_q[COORD_BITS-1];
	assign fin_val = neg_q ? $signed(COORD_BITS'(0) - accum_q) : $signed(accum_q);
	assign fin_x   = rel_q ? sat_add(held_x_q, pen_x_q) : held_x_q;
	assign fin_y   = rel_q ? sat_add(fin_val, pen_y_q) : fin_val;
	assign fin_seg = drawing_q && ((fin_x != pen_x_q) || (fin_y != pen_y_q));

	// character inside a coordinate list
	always_comb begin
		cc_num   = 1'b0;
		cc_accum = '0;
		cc_neg   = 1'b0;
		if (is_sep) begin
			cc_phase = PH_COORDS;
		end else if (is_semi) begin
			cc_phase = PH_IDLE;
		end else if (is_digit) begin
			cc_phase = PH_DIGITS;
			cc_num   = 1'b1;
			cc_accum = COORD_BITS'(digit);
		end else if (is_sign) begin
			cc_phase = PH_SIGN;
			cc_num   = 1'b1;
			cc_neg   = (ch == CH_MINUS);
		end else begin
			cc_phase = PH_SKIP;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		letter_d   = letter_q;
		drawing_d  = drawing_q;
		rel_d      = rel_q;
		pen_x_d    = pen_x_q;
		pen_y_d    = pen_y_q;
		held_x_d   = held_x_q;
		accum_d    = accum_q;
		neg_d      = neg_q;
		wait_y_d   = wait_y_q;
		seg_v      = 1'b0;
		if (is_eol) begin
			if (phase_q == PH_DIGITS && !fin_bad) begin
				if (!wait_y_q) begin
					held_x_d = fin_val;
				end else begin
					pen_x_d = fin_x;
					pen_y_d = fin_y;
					seg_v   = fin_seg;
				end
			end
			phase_d  = PH_IDLE;
			letter_d = LET_NONE;
			wait_y_d = 1'b0;
			accum_d  = '0;
			neg_d    = 1'b0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (is_sep || is_semi) begin
						phase_d = PH_IDLE;
					end else if (ch == CH_I) begin
						letter_d = LET_I;
						phase_d  = PH_LETTER;
					end else if (ch == CH_P) begin
						letter_d = LET_P;
						phase_d  = PH_LETTER;
					end else begin
						phase_d = PH_SKIP;
					end
				end
				PH_LETTER: begin
					if (letter_q == LET_I && ch == CH_N) begin
						pen_x_d    = '0;
						pen_y_d    = '0;
						held_x_d   = '0;
						drawing_d  = 1'b0;
						rel_d      = 1'b0;
						wait_y_d   = 1'b0;
						phase_d    = PH_AFTER_IN;
					end else if (letter_q == LET_P && (ch == CH_D || ch == CH_U
						|| ch == CH_R || ch == CH_A)) begin
						if (ch == CH_D) begin
							drawing_d = 1'b1;
						end else if (ch == CH_U) begin
							drawing_d = 1'b0;
						end else if (ch == CH_R) begin
							rel_d = 1'b1;
						end else begin
							rel_d = 1'b0;
						end
						wait_y_d = 1'b0;
						accum_d  = '0;
						neg_d    = 1'b0;
						phase_d  = PH_COORDS;
					end else begin
						phase_d = is_semi ? PH_IDLE : PH_SKIP;
					end
					letter_d = LET_NONE;
				end
				PH_AFTER_IN: begin
					if (is_semi) begin
						phase_d = PH_IDLE;
					end else if (!is_sep) begin
						phase_d = PH_SKIP;
					end
				end
				PH_COORDS: begin
					phase_d = cc_phase;
					if (cc_num) begin
						accum_d = cc_accum;
						neg_d   = cc_neg;
					end
				end
				PH_SIGN: begin
					if (is_digit) begin
						accum_d = COORD_BITS'(digit);
						phase_d = PH_DIGITS;
					end else begin
						accum_d = '0;
						neg_d   = 1'b0;
						phase_d = is_semi ? PH_IDLE : PH_SKIP;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						if (next_accum > MAG_LIMIT) begin
							accum_d = '0;
							neg_d   = 1'b0;
							phase_d = PH_SKIP;
						end else begin
							accum_d = next_accum[COORD_BITS-1:0];
						end
					end else if (fin_bad) begin
						accum_d = '0;
						neg_d   = 1'b0;
						phase_d = is_semi ? PH_IDLE : PH_SKIP;
					end else begin
						if (!wait_y_q) begin
							held_x_d = fin_val;
							wait_y_d = 1'b1;
						end else begin
							wait_y_d = 1'b0;
							pen_x_d  = fin_x;
							pen_y_d  = fin_y;
							seg_v    = fin_seg;
						end
						accum_d = cc_accum;
						neg_d   = cc_neg;
						phase_d = cc_phase;
					end
				end
				default: begin
					phase_d = is_semi ? PH_IDLE : PH_SKIP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			letter_q   <= LET_NONE;
			drawing_q  <= 1'b0;
			rel_q      <= 1'b0;
			pen_x_q    <= '0;
			pen_y_q    <= '0;
			held_x_q   <= '0;
			accum_q    <= '0;
			neg_q      <= 1'b0;
			wait_y_q   <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			letter_q   <= letter_d;
			drawing_q  <= drawing_d;
			rel_q      <= rel_d;
			pen_x_q    <= pen_x_d;
			pen_y_q    <= pen_y_d;
			held_x_q   <= held_x_d;
			accum_q    <= accum_d;
			neg_q      <= neg_d;
			wait_y_q   <= wait_y_d;
		end
	end

	// segment endpoints, unscaled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid_s1 <= 1'b0;
		end else if (accept) begin
			seg_valid_s1 <= seg_v;
		end else if (s2_ready) begin
			seg_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && seg_v) begin
			sx_s1 <= pen_x_q;
			sy_s1 <= pen_y_q;
			ex_s1 <= pen_x_d;
			ey_s1 <= pen_y_d;
		end
	end

	// scaled result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_ready) begin
			out_valid_q <= seg_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && seg_valid_s1) begin
			start_x_q <= OUT_BITS'(sx_s1) * SCALE_W;
			start_y_q <= OUT_BITS'(sy_s1) * SCALE_W;
			end_x_q   <= OUT_BITS'(ex_s1) * SCALE_W;
			end_y_q   <= OUT_BITS'(ey_s1) * SCALE_W;
		end
	end

	assign out_valid = out_valid_q;
	assign start_x   = start_x_q;
	assign start_y   = start_y_q;
	assign end_x     = end_x_q;
	assign end_y     = end_y_q;

	`HPCP_ASSERT_NOW(a_seg_moves, seg_valid_s1, (sx_s1 != ex_s1) || (sy_s1 != ey_s1), "zero move")
	`HPCP_ASSERT_NEXT(a_eol_idle, accept && is_eol, (phase_q == PH_IDLE) && !wait_y_q, "eol busy")
	`HPCP_ASSERT_NOW(a_accum_range, phase_q == PH_DIGITS, TW'(accum_q) <= MAG_LIMIT, "accum range")

endmodule
